// ----- rtl/core/three_level_priority_queue_macros.svh -----
// Assertion macros for the three-level priority queue.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define TLPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("three_level_priority_queue: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define TLPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("three_level_priority_queue: next-cycle check failed");

`endif

// ----- rtl/core/tlpq_pkg.sv -----
// Shared types and constants for the three-level priority queue.
// No dependencies; imported by three_level_priority_queue.
package tlpq_pkg;

    localparam int CAPACITY   = 16;
    localparam int NUM_LEVELS = 3;
    localparam int PTR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ADDR_W     = $clog2(NUM_LEVELS * CAPACITY);
    localparam int DEPTH      = NUM_LEVELS * CAPACITY;
    localparam int CNT_W      = 5;
    localparam int VAL_W      = 32;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_PRI = 2'd3
    } t_status;

    localparam logic [1:0] LVL_NONE = 2'd0;

    typedef struct packed {
        t_action                  action;
        logic signed [VAL_W-1:0]  value;
        logic [1:0]               priority_req;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  out_value;
        logic [1:0]               out_level;
        logic [CNT_W-1:0]         total_count;
        logic [CNT_W-1:0]         low_count;
        logic [CNT_W-1:0]         medium_count;
        logic [CNT_W-1:0]         high_count;
    } t_out_item;

endpackage

// ----- rtl/core/three_level_priority_queue.sv -----
// Three-level strict-priority queue: per-level rings in one synchronous store.
// Depends on tlpq_pkg and three_level_priority_queue_macros.svh.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// A push, a clear, or a pop or peek of an empty queue gives its result in the
// cycle after acceptance; other pops and peeks read the item store, then load the
// output register. One transaction is in flight at a time; the next is accepted
// while the previous result waits in the output register, once it can take it.
// Reset is synchronous and clears pointers and counts; the store needs no clearing.
// A stalled output holds its result and stalls the input side in turn.
`include "three_level_priority_queue_macros.svh"

module three_level_priority_queue
    import tlpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state             r_state;
    logic               r_out_valid;
    t_out_item          r_res;
    t_out_item          n_res;

    logic [PTR_W-1:0]   r_rd_ptr [NUM_LEVELS];
    logic [PTR_W-1:0]   r_wr_ptr [NUM_LEVELS];
    logic [CNT_W-1:0]   r_cnt    [NUM_LEVELS];
    logic [PTR_W-1:0]   n_rd_ptr [NUM_LEVELS];
    logic [PTR_W-1:0]   n_wr_ptr [NUM_LEVELS];
    logic [CNT_W-1:0]   n_cnt    [NUM_LEVELS];

    logic [VAL_W-1:0]   r_mem [DEPTH];
    logic [VAL_W-1:0]   r_rd_data;

    logic               in_acc;
    logic [CNT_W+1:0]   total;
    logic [CNT_W+1:0]   n_total;
    logic               has_top;
    logic [1:0]         top_idx;
    logic [1:0]         push_idx;
    logic [PTR_W-1:0]   sel_wr_ptr;
    logic [PTR_W-1:0]   sel_rd_ptr;
    logic               push_ok;
    logic               take_ok;
    logic               pop_ok;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    // Stall while a read is outstanding or the output cannot drain
    assign o_in_stall  = (r_state == S_READ) || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_res;

    // Pick the highest non-empty level and the push level
    always_comb begin
        total    = (CNT_W+2)'(r_cnt[0]) + (CNT_W+2)'(r_cnt[1]) + (CNT_W+2)'(r_cnt[2]);
        has_top  = 1'b0;
        top_idx  = 2'd0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (r_cnt[i] != '0) begin
                has_top = 1'b1;
                top_idx = 2'(i);
            end
        end
        push_idx   = i_in_data.priority_req - 2'd1;
        sel_wr_ptr = '0;
        sel_rd_ptr = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (push_idx == 2'(i)) begin
                sel_wr_ptr = r_wr_ptr[i];
            end
            if (top_idx == 2'(i)) begin
                sel_rd_ptr = r_rd_ptr[i];
            end
        end
        push_ok = (i_in_data.action == ACT_PUSH) && (i_in_data.priority_req != 2'd0)
                  && (total < (CNT_W+2)'(CAPACITY));
        take_ok = ((i_in_data.action == ACT_POP) || (i_in_data.action == ACT_PEEK)) && has_top;
        pop_ok  = (i_in_data.action == ACT_POP) && has_top;
        wr_addr = ADDR_W'(push_idx) * ADDR_W'(CAPACITY) + ADDR_W'(sel_wr_ptr);
        rd_addr = ADDR_W'(top_idx) * ADDR_W'(CAPACITY) + ADDR_W'(sel_rd_ptr);
    end

    // Advance pointers and counts, and build the result fields
    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            n_rd_ptr[i] = r_rd_ptr[i];
            n_wr_ptr[i] = r_wr_ptr[i];
            n_cnt[i]    = r_cnt[i];
            if (i_in_data.action == ACT_CLEAR) begin
                n_rd_ptr[i] = '0;
                n_wr_ptr[i] = '0;
                n_cnt[i]    = '0;
            end else if (push_ok && (push_idx == 2'(i))) begin
                n_wr_ptr[i] = (r_wr_ptr[i] == PTR_W'(CAPACITY - 1)) ? '0
                              : r_wr_ptr[i] + PTR_W'(1);
                n_cnt[i]    = r_cnt[i] + CNT_W'(1);
            end else if (pop_ok && (top_idx == 2'(i))) begin
                n_rd_ptr[i] = (r_rd_ptr[i] == PTR_W'(CAPACITY - 1)) ? '0
                              : r_rd_ptr[i] + PTR_W'(1);
                n_cnt[i]    = r_cnt[i] - CNT_W'(1);
            end
        end
        n_total = (CNT_W+2)'(n_cnt[0]) + (CNT_W+2)'(n_cnt[1]) + (CNT_W+2)'(n_cnt[2]);

        n_res.status = ST_OK;
        case (i_in_data.action)
            ACT_PUSH: begin
                if (i_in_data.priority_req == 2'd0) begin
                    n_res.status = ST_BAD_PRI;
                end else if (!push_ok) begin
                    n_res.status = ST_FULL;
                end
            end
            ACT_POP, ACT_PEEK: begin
                if (!has_top) begin
                    n_res.status = ST_EMPTY;
                end
            end
            default: n_res.status = ST_OK;
        endcase
        n_res.out_value    = '0;
        n_res.out_level    = take_ok ? (top_idx + 2'd1) : LVL_NONE;
        n_res.total_count  = n_total[CNT_W-1:0];
        n_res.low_count    = n_cnt[0];
        n_res.medium_count = n_cnt[1];
        n_res.high_count   = n_cnt[2];
    end

    // Write pushed items; read the head item with registered data
    always_ff @(posedge i_clk) begin
        if (in_acc && push_ok) begin
            r_mem[wr_addr] <= i_in_data.value;
        end
        if (in_acc && take_ok) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Hold state, pointers, counts and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_rd_ptr[i] <= '0;
                r_wr_ptr[i] <= '0;
                r_cnt[i]    <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rd_ptr    <= n_rd_ptr;
                        r_wr_ptr    <= n_wr_ptr;
                        r_cnt       <= n_cnt;
                        r_res       <= n_res;
                        r_out_valid <= !take_ok;
                        if (take_ok) begin
                            r_state <= S_READ;
                        end
                    end else if (r_out_valid && !i_out_stall) begin
                        // Drop the result once the output side takes it
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    r_res.out_value <= r_rd_data;
                    r_out_valid     <= 1'b1;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TLPQ_ASSERT_SAME(a_total_bound, i_clk, i_rst_n, 1'b1, total <= (CNT_W+2)'(CAPACITY))
    `TLPQ_ASSERT_SAME(a_read_out_empty, i_clk, i_rst_n, r_state == S_READ, !r_out_valid)
    `TLPQ_ASSERT_NEXT(a_take_reads, i_clk, i_rst_n, in_acc && take_ok, r_state == S_READ)
    `TLPQ_ASSERT_NEXT(a_direct_result, i_clk, i_rst_n, in_acc && !take_ok, r_out_valid)

endmodule
